>>> rtl/core/keyword_line_frame_finder_assert.svh
// Assertion macros for the keyword line frame finder checker.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef KEYWORD_LINE_FRAME_FINDER_ASSERT_SVH
`define KEYWORD_LINE_FRAME_FINDER_ASSERT_SVH

// same-cycle implication
`define KWLF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kwlf check failed");

// next-cycle implication
`define KWLF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kwlf check failed");

`endif

>>> rtl/core/kwlf_pkg.sv
// Package for the keyword line frame finder: sizes, keyword table, FSM state,
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package kwlf_pkg;

  localparam int MAX_FRAME   = 1024;
  localparam int HEAD_LEN    = 10;
  localparam int NUM_KEYS    = 12;
  localparam int KEY_MAX     = 10;
  localparam int KIND_W      = 4;
  localparam int FRAME_LEN_W = 11;
  localparam int CNT_W       = $clog2(MAX_FRAME);      // holds MAX_FRAME - 1
  localparam int FILL_W      = $clog2(HEAD_LEN + 1);
  localparam int IDX_W       = $clog2(HEAD_LEN);
  localparam int KLEN_W      = $clog2(KEY_MAX + 1);
  localparam int KIDX_W      = $clog2(NUM_KEYS);

  typedef logic [7:0] byte_t;

  localparam byte_t CHAR_CR     = 8'h0D;
  localparam byte_t CHAR_LF     = 8'h0A;
  localparam byte_t CHAR_DOLLAR = 8'h24;

  // padded on the right, compared only over KEY_LEN bytes
  localparam logic [KEY_MAX*8-1:0] KEY_TEXT [NUM_KEYS] = '{
    "$initack  ", "$auth     ", "$pos      ", "$warn     ",
    "$log      ", "$taskpau  ", "$taskcon  ", "$taskdone ",
    "$pong     ", "$sta      ", "$verify   ", "$configack"
  };

  localparam logic [KLEN_W-1:0] KEY_LEN [NUM_KEYS] = '{
    KLEN_W'(8), KLEN_W'(5), KLEN_W'(4), KLEN_W'(5), KLEN_W'(4), KLEN_W'(8),
    KLEN_W'(8), KLEN_W'(9), KLEN_W'(5), KLEN_W'(4), KLEN_W'(7), KLEN_W'(10)
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE,
    ST_MATCH,
    ST_SLIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic hunt_write;
    logic match_open;
    logic slide_shift;
    logic emit_key;
    logic emit_body_in;
    logic emit_body_win;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_frame;
    logic fill_zero;
    logic fill_last;
    logic head_dollar;
    logic key_hit;
    logic key_left_zero;
    logic body_end_win;
    logic out_space;
  } stat_t;

  // first keyword in table order that prefixes the window; 0 when none
  function automatic logic [KIND_W-1:0] find_key(input byte_t win [HEAD_LEN]);
    logic [KIND_W-1:0] kind;
    logic              hit;
    kind = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      hit = 1'b1;
      for (int c = 0; c < KEY_MAX; c++) begin
        if ((KLEN_W'(c) < KEY_LEN[k]) &&
            (win[c] != KEY_TEXT[k][(KEY_MAX-1-c)*8 +: 8])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kind = KIND_W'(k + 1);
      end
    end
    return kind;
  endfunction

endpackage

>>> rtl/core/kwlf_if.sv
// Valid/ready channel interfaces for the keyword line frame finder.
// Depends on kwlf_pkg for field widths.
`timescale 1ns / 1ps

interface kwlf_in_if;
  logic                  valid;
  logic                  ready;
  kwlf_pkg::byte_t       data_byte;
  logic                  last_in_buffer;

  modport source (output valid, data_byte, last_in_buffer, input ready);
  modport sink   (input valid, data_byte, last_in_buffer, output ready);
endinterface

interface kwlf_out_if;
  logic                                 valid;
  logic                                 ready;
  kwlf_pkg::byte_t                      frame_byte;
  logic [kwlf_pkg::KIND_W-1:0]          msg_kind;
  logic                                 end_of_frame;
  logic                                 frame_aborted;
  logic [kwlf_pkg::FRAME_LEN_W-1:0]     frame_length;
  kwlf_pkg::byte_t                      xor_check;
  logic                                 buffer_finished;

  modport source (output valid, frame_byte, msg_kind, end_of_frame, frame_aborted,
                  frame_length, xor_check, buffer_finished, input ready);
  modport sink   (input valid, frame_byte, msg_kind, end_of_frame, frame_aborted,
                  frame_length, xor_check, buffer_finished, output ready);
endinterface

>>> rtl/core/keyword_line_frame_finder.sv
// Top level of the keyword line frame finder: joins controller and datapath
// to the channel interfaces. Depends on kwlf_pkg, kwlf_if, kwlf_ctrl, kwlf_dpath.
//
//   channel   direction  words
//   in_chan   sink       data_byte, last_in_buffer
//   out_chan  source     frame_byte, msg_kind, end_of_frame, frame_aborted,
//                        frame_length, xor_check, buffer_finished
//
// A byte is accepted, then processed, while hunting or in a frame. A byte that
// fills the head window adds a compare step; a miss then slides the window one
// position a cycle until a '$' leads or the window is empty. A hit shifts window
// bytes out through the output register, one word a cycle while there is space.
// rst_n is synchronous; no clearing pass follows it. out_ready low holds the
// delivery step; no byte is accepted until it is done.
`timescale 1ns / 1ps

module keyword_line_frame_finder (
  input  logic              clk,
  input  logic              rst_n,
  kwlf_in_if.sink           in_chan,
  kwlf_out_if.source        out_chan
);
  import kwlf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  kwlf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kwlf_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_data_byte        (in_chan.data_byte),
    .in_last_in_buffer   (in_chan.last_in_buffer),
    .out_ready           (out_chan.ready),
    .out_valid           (out_chan.valid),
    .out_frame_byte      (out_chan.frame_byte),
    .out_msg_kind        (out_chan.msg_kind),
    .out_end_of_frame    (out_chan.end_of_frame),
    .out_frame_aborted   (out_chan.frame_aborted),
    .out_frame_length    (out_chan.frame_length),
    .out_xor_check       (out_chan.xor_check),
    .out_buffer_finished (out_chan.buffer_finished)
  );

endmodule

>>> rtl/core/kwlf_ctrl.sv
// Controller FSM of the keyword line frame finder: sequences intake, window
// match, window slide and byte delivery. Depends on kwlf_pkg.
`timescale 1ns / 1ps

module kwlf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  kwlf_pkg::stat_t stat,
  output kwlf_pkg::cmd_t  cmd
);
  import kwlf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (stat.in_frame) begin
          if (stat.out_space) begin
            cmd.emit_body_in = 1'b1;
            cmd.finish       = 1'b1;
            state_nxt        = ST_IDLE;
          end
        end else begin
          cmd.hunt_write = 1'b1;
          if (stat.fill_last) begin
            state_nxt = ST_MATCH;
          end else begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      ST_MATCH: begin
        if (stat.key_hit) begin
          cmd.match_open = 1'b1;
          state_nxt      = ST_EMIT;
        end else begin
          // a miss always drops at least the leading byte
          cmd.slide_shift = 1'b1;
          state_nxt       = ST_SLIDE;
        end
      end
      ST_SLIDE: begin
        if (stat.fill_zero || stat.head_dollar) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.slide_shift = 1'b1;
        end
      end
      ST_EMIT: begin
        if (stat.fill_zero) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (stat.out_space) begin
          if (!stat.key_left_zero) begin
            cmd.emit_key = 1'b1;
          end else begin
            cmd.emit_body_win = 1'b1;
            // leftover window bytes stay put as the new hunting window
            if (stat.body_end_win) begin
              cmd.finish = 1'b1;
              state_nxt  = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/kwlf_dpath.sv
// Datapath of the keyword line frame finder: head window shift register,
// frame counters, keyword compare and the output word register. Depends on kwlf_pkg.
`timescale 1ns / 1ps

module kwlf_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kwlf_pkg::cmd_t                   cmd,
  output kwlf_pkg::stat_t                  stat,
  input  kwlf_pkg::byte_t                  in_data_byte,
  input  logic                             in_last_in_buffer,
  input  logic                             out_ready,
  output logic                             out_valid,
  output kwlf_pkg::byte_t                  out_frame_byte,
  output logic [kwlf_pkg::KIND_W-1:0]      out_msg_kind,
  output logic                             out_end_of_frame,
  output logic                             out_frame_aborted,
  output logic [kwlf_pkg::FRAME_LEN_W-1:0] out_frame_length,
  output kwlf_pkg::byte_t                  out_xor_check,
  output logic                             out_buffer_finished
);
  import kwlf_pkg::*;

  byte_t              cur_r;
  logic               last_r;
  byte_t              win_r [HEAD_LEN];
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic               in_frame_r, in_frame_nxt;
  logic [KLEN_W-1:0]  key_left_r, key_left_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  byte_t              xor_r, xor_nxt;
  byte_t              prev_r, prev_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic               out_valid_r;

  logic [KIND_W-1:0]  hit_kind;
  byte_t              head;
  byte_t              ob;
  logic [CNT_W-1:0]   cnt_inc;
  logic               abort;
  logic               term_in, term_win, term;
  logic               end_in, end_win, is_end;
  logic               fin_win, fin_flag;
  logic               shift, emit, body;

  assign hit_kind = find_key(win_r);
  assign head     = win_r[0];
  assign shift    = cmd.slide_shift | cmd.emit_key | cmd.emit_body_win;
  assign body     = cmd.emit_body_in | cmd.emit_body_win;
  assign emit     = cmd.emit_key | body;
  assign ob       = cmd.emit_body_in ? cur_r : head;

  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign abort    = cnt_inc >= CNT_W'(MAX_FRAME - 1);
  assign term_in  = (cur_r == CHAR_LF) && (prev_r == CHAR_CR);
  assign term_win = (head == CHAR_LF) && (prev_r == CHAR_CR);
  assign end_in   = abort | term_in;
  assign end_win  = abort | term_win;
  // a fed-back byte ends the buffer only if it came from the newest slot
  assign fin_win  = last_r && (fill_r == FILL_W'(1));
  assign term     = cmd.emit_body_in ? term_in : term_win;
  assign is_end   = cmd.emit_body_in ? end_in : end_win;
  assign fin_flag = cmd.emit_body_in ? last_r : fin_win;

  always_comb begin
    stat.in_frame      = in_frame_r;
    stat.fill_zero     = (fill_r == '0);
    stat.fill_last     = (fill_r == FILL_W'(HEAD_LEN - 1));
    stat.head_dollar   = (head == CHAR_DOLLAR);
    stat.key_hit       = (hit_kind != '0);
    stat.key_left_zero = (key_left_r == '0);
    stat.body_end_win  = end_win;
    stat.out_space     = !out_valid_r || out_ready;
  end

  always_comb begin
    fill_nxt     = fill_r;
    in_frame_nxt = in_frame_r;
    key_left_nxt = key_left_r;
    cnt_nxt      = cnt_r;
    xor_nxt      = xor_r;
    prev_nxt     = prev_r;
    kind_nxt     = kind_r;
    if (cmd.hunt_write) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
    if (shift) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
    if (cmd.match_open) begin
      in_frame_nxt = 1'b1;
      kind_nxt     = hit_kind;
      key_left_nxt = KEY_LEN[KIDX_W'(hit_kind - KIND_W'(1))];
      cnt_nxt      = '0;
      xor_nxt      = '0;
    end
    if (emit) begin
      cnt_nxt  = cnt_inc;
      xor_nxt  = xor_r ^ ob;
      prev_nxt = ob;
    end
    if (cmd.emit_key) begin
      key_left_nxt = key_left_r - KLEN_W'(1);
    end
    if (body && is_end) begin
      in_frame_nxt = 1'b0;
    end
    // a window split across receive buffers is dropped
    if (cmd.finish && last_r) begin
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      in_frame_r  <= 1'b0;
      key_left_r  <= '0;
      cnt_r       <= '0;
      xor_r       <= '0;
      prev_r      <= '0;
      kind_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      in_frame_r <= in_frame_nxt;
      key_left_r <= key_left_nxt;
      cnt_r      <= cnt_nxt;
      xor_r      <= xor_nxt;
      prev_r     <= prev_nxt;
      kind_r     <= kind_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cur_r  <= in_data_byte;
      last_r <= in_last_in_buffer;
    end
    if (cmd.hunt_write) begin
      win_r[fill_r[IDX_W-1:0]] <= cur_r;
    end else if (shift) begin
      for (int i = 0; i < HEAD_LEN - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
    end
    if (emit) begin
      out_frame_byte      <= ob;
      out_msg_kind        <= kind_r;
      out_end_of_frame    <= body && is_end;
      out_frame_aborted   <= body && abort;
      out_frame_length    <= FRAME_LEN_W'(cnt_inc);
      out_xor_check       <= xor_r ^ ob;
      out_buffer_finished <= body && !abort && term && fin_flag;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/kwlf_checker.sv
// Port-level checker for the keyword line frame finder, bound to the top level.
// Depends on kwlf_pkg and keyword_line_frame_finder_assert.svh.
`timescale 1ns / 1ps
`include "keyword_line_frame_finder_assert.svh"

module kwlf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input kwlf_pkg::byte_t                  frame_byte,
  input logic [kwlf_pkg::KIND_W-1:0]      msg_kind,
  input logic                             end_of_frame,
  input logic [kwlf_pkg::FRAME_LEN_W-1:0] frame_length,
  input kwlf_pkg::byte_t                  xor_check
);
  import kwlf_pkg::*;

  // stalled word holds
  `KWLF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(frame_byte) && $stable(frame_length))

  // within a frame the next word counts one more byte
  `KWLF_ASSERT_NEXT(a_len_step, out_valid && out_ready && !end_of_frame, !out_valid || (frame_length == $past(frame_length) + FRAME_LEN_W'(1)))

  // running XOR folds in exactly the new byte
  `KWLF_ASSERT_NEXT(a_xor_step, out_valid && out_ready && !end_of_frame, !out_valid || (xor_check == ($past(xor_check) ^ frame_byte)))

  // keyword kind is fixed for the whole frame
  `KWLF_ASSERT_NEXT(a_kind_hold, out_valid && out_ready && !end_of_frame, !out_valid || (msg_kind == $past(msg_kind)))

endmodule

bind keyword_line_frame_finder kwlf_checker u_kwlf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .frame_byte   (out_chan.frame_byte),
  .msg_kind     (out_chan.msg_kind),
  .end_of_frame (out_chan.end_of_frame),
  .frame_length (out_chan.frame_length),
  .xor_check    (out_chan.xor_check)
);
